// File: src/smoothed_variable_delay_line_defines.svh
// ============================================================================
// Assertion macros for the smoothed variable delay line
// Shared same-cycle and next-cycle implication check forms used by the RTL.
// ============================================================================
`ifndef SMOOTHED_VARIABLE_DELAY_LINE_DEFINES_SVH
`define SMOOTHED_VARIABLE_DELAY_LINE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define SVDL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SVDL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: src/svdl_pkg.sv
// ============================================================================
// svdl_pkg
// Shared types, widths and helpers for the smoothed variable delay line.
// ============================================================================
package svdl_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_SAMPLE_RATE   = 2'd0;
    localparam logic [1:0] CFG_BUFFER_LENGTH = 2'd1;

    // Configuration reset values
    localparam logic [17:0] SAMPLE_RATE_RST   = 18'd44100;
    localparam logic [16:0] BUFFER_LENGTH_RST = 17'd65536;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 24;
    localparam int MUL_B_W = 19;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Tap before clamping: Q8.16 time * rate, fraction dropped
    localparam int TAP_W = 25;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // Saturate to the signed 16-bit sample range
    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        logic signed [15:0] r;
        if (v > 32'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -32'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// File: src/svdl_mult.sv
// ============================================================================
// svdl_mult
// Shared signed multiplier with a registered product; used for the tap
// scaling and for the feedback gain.
// ============================================================================
module svdl_mult
    import svdl_pkg::*;
(
    input  logic                      i_clk,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [PROD_W-1:0]  o_p
);

    logic signed [PROD_W-1:0] r_p;

    // One product per cycle, registered
    always_ff @(posedge i_clk) begin
        r_p <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

// File: src/svdl_store.sv
// ============================================================================
// svdl_store
// Sample ring memory: one write port, one read port with registered data.
// ============================================================================
module svdl_store #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [15:0]       i_wr_data,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [15:0]       o_rd_data
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rd_data;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/svdl_div.sv
// ============================================================================
// svdl_div
// Iterative restoring divider: signed span sum over entry count, truncated
// toward zero, one quotient bit per cycle, result saturated to 16 bits.
// ============================================================================
module svdl_div
    import svdl_pkg::*;
#(
    parameter int LW = 17
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic signed [LW+15:0]  i_dividend,
    input  logic [LW-1:0]          i_divisor,
    output t_div_stat              o_stat,
    output logic signed [15:0]     o_quotient
);

    localparam int SUMW = LW + 16;
    localparam int MW   = LW + 15;
    localparam int CNTW = $clog2(MW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [LW-1:0]   r_rem;
    logic [MW-1:0]   r_quo;
    logic [LW-1:0]   r_dvs;
    logic            r_neg;

    logic [SUMW-1:0]       w_mag;
    logic [LW:0]           w_trial;
    logic                  w_fit;
    logic signed [17:0]    w_signed_q;

    // Magnitude of the dividend; it always fits MW bits
    assign w_mag   = i_dividend[SUMW-1] ? SUMW'(-i_dividend) : SUMW'(i_dividend);

    // One restoring step
    assign w_trial = {r_rem, r_quo[MW-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dvs});

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(MW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= w_mag[MW-1:0];
            r_dvs <= i_divisor;
            r_neg <= i_dividend[SUMW-1];
        end else if (r_busy) begin
            r_rem <= w_fit ? LW'(w_trial - {1'b0, r_dvs}) : w_trial[LW-1:0];
            r_quo <= {r_quo[MW-2:0], w_fit};
        end
    end

    // Apply the sign; the magnitude is at most 32768
    assign w_signed_q = r_neg ? -$signed({1'b0, r_quo[16:0]})
                              :  $signed({1'b0, r_quo[16:0]});
    assign o_quotient = sat16(32'(w_signed_q));

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// File: src/smoothed_variable_delay_line.sv
// ============================================================================
// smoothed_variable_delay_line
// Audio delay line whose output averages the span between successive taps.
// ============================================================================
// Usage:
//   Input transactions on s_axis carry one audio sample with its delay time,
//   feedback gain and feedback sample. Each produces exactly one output
//   transaction on m_axis with the combined and wet samples.
//   Registers (sample rate, buffer length) are to be written through i_cfg_*
//   while no sample is in flight; the block itself does not enforce this.
//   Per sample the sequencer scales the delay with the shared multiplier,
//   applies the feedback gain with the same multiplier, writes the ring head,
//   then walks the N entries between the previous and current taps, one
//   memory read per cycle, and divides the sum with a one-bit-per-cycle
//   divider. A new sample is accepted only after the previous one has
//   reached the output register.
//   After reset the ring is cleared, one entry per cycle, over every entry;
//   s_axis_tready stays low meanwhile, config writes are taken.
//   The output register holds a result while m_axis_tready is low; the next
//   sample is still accepted and runs until its result waits for that slot.
// ============================================================================
`include "smoothed_variable_delay_line_defines.svh"

module smoothed_variable_delay_line
    import svdl_pkg::*;
#(
    parameter int BUFFER_DEPTH = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [17:0] i_cfg_data,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] dry_sample, [39:16] delay_time, [55:40] feedback_ratio,
    // [71:56] feedback_sample
    input  logic [71:0] s_axis_tdata,
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] combined_out, [31:16] wet_out
    output logic [31:0] m_axis_tdata
);

    localparam int AW   = $clog2(BUFFER_DEPTH);
    localparam int LW   = $clog2(BUFFER_DEPTH + 1);
    localparam int SUMW = LW + 16;
    localparam int CW   = (LW > 17) ? LW : 17;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_MTAP  = 10'b0000000100,
        S_MGAIN = 10'b0000001000,
        S_WRITE = 10'b0000010000,
        S_WALK  = 10'b0000100000,
        S_DRAIN = 10'b0001000000,
        S_DIV   = 10'b0010000000,
        S_DONE  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    // Configuration
    logic [17:0] r_sr;
    logic [16:0] r_bl;

    // Item and position registers
    logic signed [15:0] r_dry, r_ratio, r_fb;
    logic signed [23:0] r_dtime;
    logic [LW-1:0]      r_len;
    logic [AW-1:0]      r_lenm1;
    logic [AW-1:0]      r_wp, r_ptap, r_head, r_tap, r_idx, r_clr_addr;
    logic [LW-1:0]      r_remain;
    logic signed [SUMW-1:0] r_sum;
    logic               r_rd_vld;
    logic signed [15:0] r_res_wet, r_res_comb;
    logic               r_out_valid;
    logic [31:0]        r_m_tdata;

    // Combinational
    logic [CW-1:0]          w_bl;
    logic [LW-1:0]          w_len;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [16:0]     w_in_sum;
    logic [TAP_W-1:0]       w_tap_raw;
    logic signed [15:0]     w_written;
    logic [AW-1:0]          w_lo, w_hi;
    logic [LW-1:0]          w_span;
    logic [LW-1:0]          w_start_idx;
    logic                   w_accept, w_out_free;
    logic                   w_mem_we;
    logic [AW-1:0]          w_mem_waddr;
    logic [15:0]            w_mem_wdata, w_rd_data;
    logic signed [SUMW-1:0] w_sum_next;
    logic                   w_div_start;
    t_div_stat              w_div_stat;
    logic signed [15:0]     w_wet;
    logic [LW-1:0]          w_head_inc;

    // Length in use: zero acts as one, capped at the depth
    assign w_bl  = CW'(r_bl);
    assign w_len = (r_bl == 17'd0) ? LW'(1)
                 : (w_bl > CW'(BUFFER_DEPTH)) ? LW'(BUFFER_DEPTH) : LW'(w_bl);

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;

    // Shared multiplier operands: tap scaling, then feedback gain
    assign w_in_sum = 17'(r_dry) + 17'(r_fb);
    always_comb begin
        case (r_state)
            S_MTAP: begin
                w_mul_a = r_dtime[23] ? '0 : r_dtime;
                w_mul_b = $signed({1'b0, r_sr});
            end
            default: begin
                w_mul_a = MUL_A_W'(w_in_sum);
                w_mul_b = MUL_B_W'(r_ratio);
            end
        endcase
    end

    svdl_mult u_mult (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    // Tap and written sample from the product register
    assign w_tap_raw = w_prod[40:16];
    assign w_written = sat16(32'($signed(w_prod[42:14])));

    // Span bounds, entry count and the newer-end start index
    assign w_lo = (r_tap < r_ptap) ? r_tap : r_ptap;
    assign w_hi = (r_tap < r_ptap) ? r_ptap : r_tap;
    assign w_span = LW'(w_hi) - LW'(w_lo) + LW'(1);
    assign w_start_idx = LW'(r_head) + ((r_head >= w_lo) ? LW'(0) : r_len) - LW'(w_lo);

    assign w_head_inc = LW'(r_head) + LW'(1);

    // Ring memory
    assign w_mem_we    = (r_state == S_CLEAR) || (r_state == S_WRITE);
    assign w_mem_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_head;
    assign w_mem_wdata = (r_state == S_CLEAR) ? 16'd0 : w_written;

    svdl_store #(
        .DEPTH (BUFFER_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_mem_we),
        .i_wr_addr (w_mem_waddr),
        .i_wr_data (w_mem_wdata),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd_data)
    );

    // Accumulate a read issued in the previous cycle
    assign w_sum_next = r_rd_vld ? (r_sum + SUMW'($signed(w_rd_data))) : r_sum;

    assign w_div_start = (r_state == S_DRAIN);

    // Taps hold still until the result leaves, so the span count is stable here
    svdl_div #(
        .LW (LW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_sum_next),
        .i_divisor  (w_span),
        .o_stat     (w_div_stat),
        .o_quotient (w_wet)
    );

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr_addr == AW'(BUFFER_DEPTH - 1)) n_state = S_IDLE;
            S_IDLE:  if (w_accept) n_state = S_MTAP;
            S_MTAP:  n_state = S_MGAIN;
            S_MGAIN: n_state = S_WRITE;
            S_WRITE: n_state = S_WALK;
            S_WALK:  if (r_remain == LW'(1)) n_state = S_DRAIN;
            S_DRAIN: n_state = S_DIV;
            S_DIV:   if (w_div_stat.done) n_state = S_DONE;
            S_DONE:  if (w_out_free) n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_wp        <= '0;
            r_ptap      <= '0;
            r_sr        <= SAMPLE_RATE_RST;
            r_bl        <= BUFFER_LENGTH_RST;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_WALK);

            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_SAMPLE_RATE:   r_sr <= i_cfg_data;
                    CFG_BUFFER_LENGTH: r_bl <= i_cfg_data[16:0];
                    default: ;
                endcase
            end

            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end

            // Prior tap clamped into the length in use
            if (r_state == S_MTAP && LW'(r_ptap) >= r_len) begin
                r_ptap <= r_lenm1;
            end

            // Result leaves; positions advance
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
                r_wp        <= (w_head_inc >= r_len) ? '0 : w_head_inc[AW-1:0];
                r_ptap      <= r_tap;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_dry   <= $signed(s_axis_tdata[15:0]);
                r_dtime <= $signed(s_axis_tdata[39:16]);
                r_ratio <= $signed(s_axis_tdata[55:40]);
                r_fb    <= $signed(s_axis_tdata[71:56]);
                r_len   <= w_len;
                r_lenm1 <= AW'(w_len - LW'(1));
            end
            S_MTAP: begin
                r_head <= (LW'(r_wp) >= r_len) ? '0 : r_wp;
            end
            S_MGAIN: begin
                r_tap <= (w_tap_raw > TAP_W'(r_lenm1)) ? r_lenm1 : w_tap_raw[AW-1:0];
            end
            S_WRITE: begin
                r_idx    <= w_start_idx[AW-1:0];
                r_remain <= w_span;
                r_sum    <= '0;
            end
            S_WALK: begin
                r_idx    <= (r_idx == '0) ? r_lenm1 : r_idx - 1'b1;
                r_remain <= (r_remain == LW'(1)) ? r_remain : r_remain - LW'(1);
                r_sum    <= w_sum_next;
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    r_res_wet  <= w_wet;
                    r_res_comb <= sat16(32'(r_dry) + 32'(w_wet));
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_m_tdata <= {r_res_wet, r_res_comb};
                end
            end
            default: ;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_m_tdata;

    // Checks
    `SVDL_ASSERT_NEXT(a_accept_starts, w_accept, r_state == S_MTAP, "accept did not start work")
    `SVDL_ASSERT_NOW(a_walk_count, r_state == S_WALK, r_remain != '0, "walk with empty span")
    `SVDL_ASSERT_NOW(a_taps_in_len, r_state == S_WRITE, w_hi <= r_lenm1, "tap beyond length")
    `SVDL_ASSERT_NOW(a_div_idle, r_state == S_DRAIN, !w_div_stat.busy, "divider busy at start")
    `SVDL_ASSERT_NEXT(a_result_out, (r_state == S_DONE) && w_out_free, r_out_valid, "no result")

endmodule
